@@ rtl/vrp_pkg.sv @@
// Shared types, constants and saturation helper for the vertex rotate/project pipeline.
package vrp_pkg;

	localparam int COORD_FRAC_DEF = 16;
	localparam int QW = 34;   // quotient bits kept; larger magnitudes saturate
	localparam int MW = 48;   // magnitude width of a scaled coordinate

	localparam logic [22:0] PERSP_K = 23'd4294967;   // 0.001 in Q0.32

	localparam logic [31:0] TRIG_RST  = 32'h4000_0000;
	localparam logic [31:0] SCALE_RST = 32'h0001_0000;

	typedef enum logic [2:0] {
		REG_TRIG_X   = 3'd0,
		REG_TRIG_Y   = 3'd1,
		REG_TRIG_Z   = 3'd2,
		REG_CENTER_X = 3'd3,
		REG_CENTER_Y = 3'd4,
		REG_SCALE    = 3'd5
	} reg_idx_t;

	localparam logic signed [35:0] SAT_MAX = 36'sh0_7FFF_FFFF;
	localparam logic signed [35:0] SAT_MIN = 36'shF_8000_0000;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [35:0] t;
		t = v;
		if (v > SAT_MAX) t = SAT_MAX;
		else if (v < SAT_MIN) t = SAT_MIN;
		return t[31:0];
	endfunction

endpackage

@@ rtl/vrp_rot.sv @@
// One rotation stage: two Q1.14 products per output, round, saturate, register.
module vrp_rot #(
	parameter int PW = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  a,
	input  logic signed [31:0]  b,
	input  logic [31:0]         trig,
	input  logic [PW-1:0]       pass_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  o1,
	output logic signed [31:0]  o2,
	output logic [PW-1:0]       pass_out
);
	import vrp_pkg::*;

	logic signed [15:0] c, s;
	logic signed [47:0] ac, bs, bc, as_p;
	logic signed [48:0] sum1, sum2;
	logic signed [35:0] sh1, sh2;
	logic               v_s1;
	logic signed [31:0] o1_s1, o2_s1;
	logic [PW-1:0]      p_s1;

	assign c = trig[31:16];
	assign s = trig[15:0];
	assign ac = a * c;
	assign bs = b * s;
	assign bc = b * c;
	assign as_p = a * s;
	// o1 = a*c - b*s, o2 = b*c + a*s, round half up
	assign sum1 = 49'(ac) - 49'(bs) + 49'sd8192;
	assign sum2 = 49'(bc) + 49'(as_p) + 49'sd8192;
	assign sh1 = 36'(sum1 >>> 14);
	assign sh2 = 36'(sum2 >>> 14);

	assign in_ready = !v_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			o1_s1 <= sat32(sh1);
			o2_s1 <= sat32(sh2);
			p_s1 <= pass_in;
		end
	end

	assign out_valid = v_s1;
	assign o1 = o1_s1;
	assign o2 = o2_s1;
	assign pass_out = p_s1;

endmodule

@@ rtl/vrp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, two dividends over one divisor.
module vrp_div #(
	parameter int DW = 24,
	parameter int QW = 34,
	parameter int PW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [DW-1:0] d,
	input  logic [DW-1:0] r1,
	input  logic [DW-1:0] r2,
	input  logic [QW-1:0] n1,
	input  logic [QW-1:0] n2,
	input  logic [PW-1:0] pass_in,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [QW-1:0] q1,
	output logic [QW-1:0] q2,
	output logic [PW-1:0] pass_out
);

	logic          v_s   [QW];
	logic [DW-1:0] d_s   [QW];
	logic [DW-1:0] r1_s  [QW];
	logic [DW-1:0] r2_s  [QW];
	logic [QW-1:0] nq1_s [QW];  // dividend bits shift out at the top, quotient bits in below
	logic [QW-1:0] nq2_s [QW];
	logic [PW-1:0] p_s   [QW];
	logic          en    [QW+1];

	function automatic logic [DW:0] div_step(input logic [DW-1:0] r, input logic nb,
			input logic [DW-1:0] dv);
		logic [DW:0] t;
		logic [DW:0] u;
		t = {r, nb};
		u = t - {1'b0, dv};
		if (t >= {1'b0, dv}) div_step = {1'b1, u[DW-1:0]};
		else div_step = {1'b0, t[DW-1:0]};
	endfunction

	assign en[QW] = out_ready;
	assign in_ready = en[0];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic          vin;
		logic [DW-1:0] din, rin1, rin2;
		logic [QW-1:0] nin1, nin2;
		logic [PW-1:0] pin;
		logic [DW:0]   st1, st2;

		if (k == 0) begin : g_first
			assign vin = in_valid;
			assign din = d;
			assign rin1 = r1;
			assign rin2 = r2;
			assign nin1 = n1;
			assign nin2 = n2;
			assign pin = pass_in;
		end else begin : g_next
			assign vin = v_s[k-1];
			assign din = d_s[k-1];
			assign rin1 = r1_s[k-1];
			assign rin2 = r2_s[k-1];
			assign nin1 = nq1_s[k-1];
			assign nin2 = nq2_s[k-1];
			assign pin = p_s[k-1];
		end

		assign en[k] = !v_s[k] || en[k+1];
		assign st1 = div_step(rin1, nin1[QW-1], din);
		assign st2 = div_step(rin2, nin2[QW-1], din);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k] && vin) begin
				d_s[k] <= din;
				r1_s[k] <= st1[DW-1:0];
				r2_s[k] <= st2[DW-1:0];
				nq1_s[k] <= {nin1[QW-2:0], st1[DW]};
				nq2_s[k] <= {nin2[QW-2:0], st2[DW]};
				p_s[k] <= pin;
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign q1 = nq1_s[QW-1];
	assign q2 = nq2_s[QW-1];
	assign pass_out = p_s[QW-1];

endmodule

@@ rtl/vertex_rotate_project.sv @@
// Pipeline: rotations about X, Y and Z, projection setup stages 4 to 7, 34 divider
// stages and one output register, in that order; results hold while the output side stalls.
// Throughput: one vertex per cycle while the output accepts; every stage holds its own
// valid bit, so bubbles fill while the output waits. The 34-stage divider sets the depth.
// Reset: arst_n clears all valid bits and loads the configuration reset values.
module vertex_rotate_project #(
	parameter int COORD_FRAC_BITS = vrp_pkg::COORD_FRAC_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // vertex_x, vertex_y, vertex_z
	input  logic        s_tlast,   // last_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // screen_x, screen_y
	output logic [0:0]  m_tuser,   // behind_camera
	output logic        m_tlast,   // last_out
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import vrp_pkg::*;

	localparam int F    = COORD_FRAC_BITS;
	localparam int DW   = ((F > 22) ? F : 22) + 2;
	localparam int DSW  = DW + 1;
	localparam int NW   = MW + 1 + F;
	localparam int HW   = NW - QW;
	localparam int CMPW = (HW > DW) ? HW : DW;
	localparam logic signed [DSW-1:0] D_ONE = DSW'(64'sd1 << F);
	localparam logic signed [DSW-1:0] D_LIM = DSW'(64'sd1 << (F - 8));

	// configuration
	logic [31:0]        trig_x_q, trig_y_q, trig_z_q, scale_q;
	logic signed [31:0] center_x_q, center_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_x_q <= TRIG_RST;
			trig_y_q <= TRIG_RST;
			trig_z_q <= TRIG_RST;
			center_x_q <= '0;
			center_y_q <= '0;
			scale_q <= SCALE_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TRIG_X:   trig_x_q <= cfg_data;
				REG_TRIG_Y:   trig_y_q <= cfg_data;
				REG_TRIG_Z:   trig_z_q <= cfg_data;
				REG_CENTER_X: center_x_q <= cfg_data;
				REG_CENTER_Y: center_y_q <= cfg_data;
				REG_SCALE:    scale_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	// rotation about X, Y, Z
	logic               r1_valid, r1_ready, r2_valid, r2_ready, r3_valid, r3_ready;
	logic signed [31:0] y1, z1, x2, z2, x3, y3;
	logic [32:0]        r1_pass, r2_pass, r3_pass;

	vrp_rot #(.PW(33)) u_rot_x (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.a(s_tdata[63:32]), .b(s_tdata[95:64]), .trig(trig_x_q),
		.pass_in({s_tlast, s_tdata[31:0]}),
		.out_valid(r1_valid), .out_ready(r1_ready),
		.o1(y1), .o2(z1), .pass_out(r1_pass)
	);

	vrp_rot #(.PW(33)) u_rot_y (
		.clk(clk), .arst_n(arst_n),
		.in_valid(r1_valid), .in_ready(r1_ready),
		.a(z1), .b(r1_pass[31:0]), .trig(trig_y_q),
		.pass_in({r1_pass[32], y1}),
		.out_valid(r2_valid), .out_ready(r2_ready),
		.o1(z2), .o2(x2), .pass_out(r2_pass)
	);

	vrp_rot #(.PW(33)) u_rot_z (
		.clk(clk), .arst_n(arst_n),
		.in_valid(r2_valid), .in_ready(r2_ready),
		.a(x2), .b(r2_pass[31:0]), .trig(trig_z_q),
		.pass_in({r2_pass[32], z2}),
		.out_valid(r3_valid), .out_ready(r3_ready),
		.o1(x3), .o2(y3), .pass_out(r3_pass)
	);

	logic en4, en5, en6, en7, en_out, div_in_ready, div_valid;
	logic v_s4, v_s5, v_s6, v_s7, vo_q;

	// stage 4: scale and perspective products
	logic signed [64:0] px_s4, py_s4;
	logic signed [55:0] pz_s4;
	logic               last_s4;

	assign en4 = !v_s4 || en5;
	assign r3_ready = en4;

	always_ff @(posedge clk) begin
		if (en4 && r3_valid) begin
			px_s4 <= x3 * $signed({1'b0, scale_q});
			py_s4 <= y3 * $signed({1'b0, scale_q});
			pz_s4 <= $signed(r3_pass[31:0]) * $signed({1'b0, PERSP_K});
			last_s4 <= r3_pass[32];
		end
	end

	// stage 5: rounding shifts, denominator, behind-camera test
	logic signed [23:0]    dz;
	logic signed [DSW-1:0] dsum;
	logic signed [48:0]    mx_s5, my_s5;
	logic signed [DSW-1:0] d_s5;
	logic                  behind_s5, last_s5;

	assign dz = 24'((pz_s4 + 56'sd2147483648) >>> 32);
	assign dsum = D_ONE + DSW'(dz);
	assign en5 = !v_s5 || en6;

	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			mx_s5 <= 49'((px_s4 + 65'sd32768) >>> 16);
			my_s5 <= 49'((py_s4 + 65'sd32768) >>> 16);
			d_s5 <= dsum;
			behind_s5 <= (dsum <= D_LIM);
			last_s5 <= last_s4;
		end
	end

	// stage 6: magnitude and rounded dividend m * 2^F + d/2
	logic [48:0]   magx, magy;
	logic [NW-1:0] nx_s6, ny_s6;
	logic [DW-1:0] d_s6;
	logic          negx_s6, negy_s6, behind_s6, last_s6;
	logic [DW-1:0] d5u;

	assign magx = mx_s5[48] ? 49'(-mx_s5) : 49'(mx_s5);
	assign magy = my_s5[48] ? 49'(-my_s5) : 49'(my_s5);
	assign d5u = d_s5[DW-1:0];
	assign en6 = !v_s6 || en7;

	always_ff @(posedge clk) begin
		if (en6 && v_s5) begin
			nx_s6 <= (NW'(magx[MW-1:0]) << F) + NW'(d5u >> 1);
			ny_s6 <= (NW'(magy[MW-1:0]) << F) + NW'(d5u >> 1);
			d_s6 <= d5u;
			negx_s6 <= mx_s5[48];
			negy_s6 <= my_s5[48];
			behind_s6 <= behind_s5;
			last_s6 <= last_s5;
		end
	end

	// stage 7: quotient range check and divider seed
	logic [HW-1:0] hx, hy;
	logic [DW-1:0] rx_s7, ry_s7, d_s7;
	logic [QW-1:0] lx_s7, ly_s7;
	logic [5:0]    pass_s7;

	assign hx = nx_s6[NW-1:QW];
	assign hy = ny_s6[NW-1:QW];
	assign en7 = !v_s7 || div_in_ready;

	always_ff @(posedge clk) begin
		if (en7 && v_s6) begin
			rx_s7 <= DW'(hx);
			ry_s7 <= DW'(hy);
			lx_s7 <= nx_s6[QW-1:0];
			ly_s7 <= ny_s6[QW-1:0];
			d_s7 <= d_s6;
			// {last, behind, overflow y, overflow x, neg y, neg x}
			pass_s7 <= {last_s6, behind_s6, (CMPW'(hy) >= CMPW'(d_s6)),
				(CMPW'(hx) >= CMPW'(d_s6)), negy_s6, negx_s6};
		end
	end

	logic [QW-1:0] qx, qy;
	logic [5:0]    pass_d;

	vrp_div #(.DW(DW), .QW(QW), .PW(6)) u_div (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s7), .in_ready(div_in_ready),
		.d(d_s7), .r1(rx_s7), .r2(ry_s7), .n1(lx_s7), .n2(ly_s7),
		.pass_in(pass_s7),
		.out_valid(div_valid), .out_ready(en_out),
		.q1(qx), .q2(qy), .pass_out(pass_d)
	);

	// output: sign, center offset, saturation, behind-camera override
	logic signed [QW+1:0] vx, vy, sumx, sumy;
	logic signed [31:0]   resx, resy;
	logic signed [31:0]   sx_q, sy_q;
	logic                 behind_q, last_q;

	assign vx = pass_d[0] ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
	assign vy = pass_d[1] ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
	assign sumx = (QW+2)'(center_x_q) + vx;
	assign sumy = (QW+2)'(center_y_q) + vy;

	always_comb begin
		resx = sat32(sumx);
		resy = sat32(sumy);
		if (pass_d[2]) resx = pass_d[0] ? SAT_MIN[31:0] : SAT_MAX[31:0];
		if (pass_d[3]) resy = pass_d[1] ? SAT_MIN[31:0] : SAT_MAX[31:0];
		if (pass_d[4]) begin
			resx = center_x_q;
			resy = center_y_q;
		end
	end

	assign en_out = !vo_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (en4) v_s4 <= r3_valid;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
			if (en_out) vo_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && div_valid) begin
			sx_q <= resx;
			sy_q <= resy;
			behind_q <= pass_d[4];
			last_q <= pass_d[5];
		end
	end

	assign m_tvalid = vo_q;
	assign m_tdata = {sy_q, sx_q};
	assign m_tuser = behind_q;
	assign m_tlast = last_q;

endmodule

@@ rtl/vrp_chk.sv @@
// Port-level checker for vertex_rotate_project, attached by bind.
module vrp_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        m_tlast
);
	import vrp_pkg::*;

	logic [7:0] cnt_q;   // transactions in flight
	logic       acc_in, acc_out;

	assign acc_in = s_tvalid && s_tready;
	assign acc_out = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 8'(acc_in) - 8'(acc_out);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready || !m_tvalid |-> s_tready)
		else $error("input stalled with a free output");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cnt_q != 8'd0)
		else $error("result with no vertex in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 8'(QW + 8))
		else $error("more vertices in flight than pipeline stages");

endmodule

bind vertex_rotate_project vrp_chk u_vrp_chk (.*);
